>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/deq_pkg.sv
// Shared types and constants of the double-ended queue.
// No dependencies.
package deq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CNT_W_DEFAULT = $clog2(DEPTH_DEFAULT + 1);
  localparam int FUNC_W        = 3;
  localparam int VALUE_W       = 32;
  localparam int POS_W         = 4;
  localparam int STATUS_W      = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_REAR  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_REAR   = 3'd3,
    FN_READ       = 3'd4,
    FN_SWAP       = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

>>> rtl/core/deq_if.sv
// Valid/ready channels of the double-ended queue: operation request and result.
// Depends on deq_pkg.
interface deq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [deq_pkg::FUNC_W-1:0]           func;
  logic signed [deq_pkg::VALUE_W-1:0]   value;
  logic [deq_pkg::POS_W-1:0]            position_a;
  logic [deq_pkg::POS_W-1:0]            position_b;

  modport source (output valid, func, value, position_a, position_b, input ready);
  modport sink   (input valid, func, value, position_a, position_b, output ready);
endinterface

interface deq_rsp_if #(
  parameter int CNT_W = deq_pkg::CNT_W_DEFAULT
);
  logic                                 valid;
  logic                                 ready;
  logic signed [deq_pkg::VALUE_W-1:0]   data_out;
  logic [deq_pkg::STATUS_W-1:0]         status;
  logic [CNT_W-1:0]                     count_out;

  modport source (output valid, data_out, status, count_out, input ready);
  modport sink   (input valid, data_out, status, count_out, output ready);
endinterface

>>> rtl/core/deq_ram.sv
// Generic RAM: one write port, two read ports with registered, enabled read.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

>>> rtl/core/double_ended_queue_unit.sv
// Top level of the double-ended queue: head/count control, element RAM, result register.
// Depends on deq_pkg, deq_if and deq_ram.
//
// One operation is accepted per cycle unless the commit stage is held; its result goes
// from the commit stage into the result register, held while the result side stalls.
// Head and count update at acceptance; element data is read from the RAM at acceptance
// and written from the commit stage, with a bypass for a read that meets that write.
// A swap of two distinct positions needs two writes on the RAM's single write port, so
// it holds the commit stage and the request side for a second write phase. No clearing pass after reset.
module double_ended_queue_unit #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input logic        clk,
  input logic        rst,
  deq_req_if.sink    req,
  deq_rsp_if.source  rsp
);

  localparam int PW  = deq_pkg::POS_W;
  localparam int VW  = deq_pkg::VALUE_W;
  localparam int MW1 = (AW > PW) ? AW : PW;
  localparam int MW  = (MW1 > CW) ? MW1 : CW;
  localparam int SW  = MW + 1;

  function automatic logic [AW-1:0] wrap_slot(input logic [AW-1:0] base,
                                               input logic [SW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + off;
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // control state
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count_next;

  // accept side
  deq_pkg::func_t   fn;
  deq_pkg::status_t status_next;
  logic [SW-1:0]    pa_x, pb_x, cnt_x, off_a;
  logic [AW-1:0]    slot_a, slot_b, head_inc;
  logic             acc;

  // commit stage
  logic             s1_valid;
  logic             s1_phase;
  deq_pkg::func_t   s1_func;
  deq_pkg::status_t s1_status;
  logic [VW-1:0]    s1_value;
  logic [AW-1:0]    s1_slot_a, s1_slot_b;
  logic [CW-1:0]    s1_count;
  logic             s1_fwd_a, s1_fwd_b;
  logic [VW-1:0]    s1_fwd_data;
  logic             s1_ok, s1_push, s1_take, swap_x, s1_fire, o_free;
  logic [VW-1:0]    rd_data_a, rd_data_b, opa, opb;

  // memory write
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VW-1:0]    wr_data;

  // result register
  logic                       o_valid;
  logic signed [VW-1:0]       o_data;
  logic [deq_pkg::STATUS_W-1:0] o_status;
  logic [CW-1:0]              o_count;

  assign acc = req.valid && req.ready;

  always_comb begin
    fn          = deq_pkg::func_t'(req.func);
    pa_x        = SW'(req.position_a);
    pb_x        = SW'(req.position_b);
    cnt_x       = SW'(count);
    off_a       = '0;
    status_next = deq_pkg::ST_OK;
    unique case (fn)
      deq_pkg::FN_PUSH_FRONT: begin
        off_a = SW'(DEPTH - 1);
        if (count == CW'(DEPTH)) status_next = deq_pkg::ST_FULL;
      end
      deq_pkg::FN_PUSH_REAR: begin
        off_a = cnt_x;
        if (count == CW'(DEPTH)) status_next = deq_pkg::ST_FULL;
      end
      deq_pkg::FN_POP_FRONT: begin
        off_a = '0;
        if (count == '0) status_next = deq_pkg::ST_EMPTY;
      end
      deq_pkg::FN_POP_REAR: begin
        off_a = cnt_x - 1'b1;
        if (count == '0) status_next = deq_pkg::ST_EMPTY;
      end
      deq_pkg::FN_READ: begin
        off_a = pa_x;
        if (pa_x >= cnt_x) status_next = deq_pkg::ST_RANGE;
      end
      deq_pkg::FN_SWAP: begin
        off_a = pa_x;
        if (pa_x >= cnt_x || pb_x >= cnt_x) status_next = deq_pkg::ST_RANGE;
      end
      default: begin
        off_a       = '0;
        status_next = deq_pkg::ST_OK;
      end
    endcase
  end

  assign slot_a   = wrap_slot(head, off_a);
  assign slot_b   = wrap_slot(head, pb_x);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : AW'(head + 1'b1);

  always_comb begin
    head_next  = head;
    count_next = count;
    if (status_next == deq_pkg::ST_OK) begin
      case (fn)
        deq_pkg::FN_PUSH_FRONT: begin
          head_next  = slot_a;
          count_next = CW'(count + 1'b1);
        end
        deq_pkg::FN_PUSH_REAR: count_next = CW'(count + 1'b1);
        deq_pkg::FN_POP_FRONT: begin
          head_next  = head_inc;
          count_next = CW'(count - 1'b1);
        end
        deq_pkg::FN_POP_REAR: count_next = CW'(count - 1'b1);
        default: count_next = count;
      endcase
    end
  end

  // commit stage control
  assign s1_ok   = (s1_status == deq_pkg::ST_OK);
  assign s1_push = (s1_func == deq_pkg::FN_PUSH_FRONT) || (s1_func == deq_pkg::FN_PUSH_REAR);
  assign s1_take = (s1_func == deq_pkg::FN_POP_FRONT) || (s1_func == deq_pkg::FN_POP_REAR)
                || (s1_func == deq_pkg::FN_READ);
  assign swap_x  = (s1_func == deq_pkg::FN_SWAP) && s1_ok && (s1_slot_a != s1_slot_b);
  assign o_free  = !o_valid || rsp.ready;
  assign s1_fire = s1_valid && (!swap_x || s1_phase) && o_free;
  assign req.ready = !s1_valid || s1_fire;

  assign opa = s1_fwd_a ? s1_fwd_data : rd_data_a;
  assign opb = s1_fwd_b ? s1_fwd_data : rd_data_b;

  // swap: first write puts b into slot a, second write puts a into slot b
  assign wr_en   = (s1_valid && swap_x && !s1_phase)
                || (s1_fire && ((s1_push && s1_ok) || swap_x));
  assign wr_addr = (swap_x && s1_phase) ? s1_slot_b : s1_slot_a;
  assign wr_data = s1_push ? s1_value : (s1_phase ? opa : opb);

  deq_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_deq_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (acc),
    .rd_addr_a (slot_a),
    .rd_addr_b (slot_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (acc) begin
        head  <= head_next;
        count <= count_next;
      end
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (acc || s1_fire) begin
        s1_phase <= 1'b0;
      end else if (s1_valid && swap_x && !s1_phase) begin
        s1_phase <= 1'b1;
      end
      if (s1_fire) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_func     <= fn;
      s1_status   <= status_next;
      s1_value    <= req.value;
      s1_slot_a   <= slot_a;
      s1_slot_b   <= slot_b;
      s1_count    <= count_next;
      s1_fwd_a    <= wr_en && (wr_addr == slot_a);
      s1_fwd_b    <= wr_en && (wr_addr == slot_b);
      s1_fwd_data <= wr_data;
    end
    if (s1_fire) begin
      o_data   <= (s1_ok && s1_take) ? opa : '0;
      o_status <= s1_status;
      o_count  <= s1_count;
    end
  end

  assign rsp.valid     = o_valid;
  assign rsp.data_out  = o_data;
  assign rsp.status    = o_status;
  assign rsp.count_out = o_count;

endmodule

>>> rtl/core/deq_checker.sv
// Port-level checker for double_ended_queue_unit, attached by bind.
// Depends on deq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module deq_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [deq_pkg::STATUS_W-1:0]  out_status,
  input logic [CW-1:0]                 out_count
);

  logic          in_acc, out_acc;
  logic [1:0]    pend;
  logic [CW-1:0] last_cnt;
  logic          have_last;
  logic          step_ok;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // a delivered count moves by at most one per transaction
  assign step_ok = ({1'b0, out_count} == {1'b0, last_cnt})
                || ({1'b0, out_count} == {1'b0, last_cnt} + 1'b1)
                || ({1'b0, out_count} + 1'b1 == {1'b0, last_cnt});

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      have_last <= 1'b0;
    end else begin
      if (in_acc && !out_acc) begin
        pend <= pend + 1'b1;
      end else if (!in_acc && out_acc) begin
        pend <= pend - 1'b1;
      end
      if (out_acc) begin
        have_last <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      last_cnt <= out_count;
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `ASSERT_IMPL(a_no_invent, clk, rst, out_valid, pend != 2'd0, "result without request")
  `ASSERT_IMPL(a_pend_max, clk, rst, 1'b1, pend != 2'd3, "too many transactions in flight")
  `ASSERT_IMPL(a_full_cnt, clk, rst, out_valid && out_status == deq_pkg::ST_FULL, out_count == CW'(DEPTH), "full with short count")
  `ASSERT_IMPL(a_cnt_step, clk, rst, out_acc && have_last, step_ok, "count jumped")

endmodule

bind double_ended_queue_unit deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_status (rsp.status),
  .out_count  (rsp.count_out)
);
